FILE: sv/mdf_pkg.sv
// Shared types and constants for the multicast duplicate forward filter.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package mdf_pkg;

	// Sequence-ID cache depth and its index width
	localparam int TABLE_DEPTH = 4;
	localparam int PTR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// Field widths
	localparam int SEQ_W = 15;
	localparam int LEN_W = 16;
	localparam int DLY_W = 16;
	localparam int SPREAD_W = 8;
	localparam int CNT_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int MOD_STEPS = 16;
	localparam int STEP_W = $clog2(MOD_STEPS);

	// Header constants
	localparam logic [7:0] OPT_TYPE_MCAST = 8'h0C;
	localparam logic [7:0] OPT_LEN_MCAST = 8'd2;
	localparam logic [LEN_W-1:0] ADDED_BYTES = 16'd8;
	localparam logic [LEN_W-1:0] IPV6_HDR_BYTES = 16'd40;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPREAD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FORWARDS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT = 3'd4;

	// Command codes and verdicts
	localparam logic CMD_INBOUND = 1'b0;
	localparam logic CMD_OUTBOUND = 1'b1;
	localparam logic [1:0] VERDICT_DROP = 2'd0;
	localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
	localparam logic [1:0] VERDICT_SENT = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic load;      // capture the input request
		logic eval;      // header check, table lookup and state update
		logic mod_step;  // one restoring step of random mod spread
		logic mul;       // scale base delay by the spread factor
		logic out_load;  // move the result into the output register
	} mdf_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic fwd;          // eval: a forward is scheduled
		logic spread_zero;  // no randomization configured
		logic mod_last;     // final modulo step in progress
	} mdf_status_t;

endpackage
`default_nettype wire

FILE: sv/mdf_ctrl.sv
// Controller state machine for the multicast duplicate forward filter.
// Depends on mdf_pkg for the command and status structs.
`default_nettype none
module mdf_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire                  out_ready,
	input  mdf_pkg::mdf_status_t status,
	output mdf_pkg::mdf_cmd_t    cmd
);
	import mdf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MOD,
		ST_MUL,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid || out_ready;

	// Decode commands from the current state
	always_comb begin
		cmd = '0;
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.eval = (state_q == ST_EVAL);
		cmd.mod_step = (state_q == ST_MOD);
		cmd.mul = (state_q == ST_MUL);
		cmd.out_load = (state_q == ST_FINISH) && out_free;
	end

	// Hold state and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (!status.fwd) state_q <= ST_FINISH;
					else if (status.spread_zero) state_q <= ST_MUL;
					else state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (status.mod_last) state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/mdf_dpath.sv
// Datapath: configuration, sequence-ID cache, iterative modulo, delay scaling
// and the output register. Depends on mdf_pkg.
`default_nettype none
module mdf_dpath (
	input  wire                               clk,
	input  wire                               arst_n,
	input  mdf_pkg::mdf_cmd_t                 cmd,
	output mdf_pkg::mdf_status_t              status,
	input  wire                               cfg_wen,
	input  wire [mdf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [mdf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire                               command,
	input  wire [7:0]                         ttl,
	input  wire                               proto_is_hbh,
	input  wire [7:0]                         option_type,
	input  wire [7:0]                         option_len,
	input  wire [7:0]                         seq_high,
	input  wire [7:0]                         seq_low,
	input  wire                               timer_idle,
	input  wire [15:0]                        random_value,
	input  wire                               is_member,
	input  wire                               source_unspecified,
	input  wire [mdf_pkg::LEN_W-1:0]          packet_len,
	output logic [1:0]                        verdict,
	output logic                              forward_now,
	output logic [mdf_pkg::DLY_W-1:0]         forward_delay,
	output logic [mdf_pkg::SEQ_W-1:0]         out_seq,
	output logic [mdf_pkg::LEN_W-1:0]         out_len,
	output logic [mdf_pkg::LEN_W-1:0]         out_payload_len
);
	import mdf_pkg::*;

	// Configuration registers
	logic [DLY_W-1:0]    check_interval_q;
	logic [DLY_W-1:0]    min_delay_q;
	logic [SPREAD_W-1:0] max_spread_q;
	logic [CNT_W-1:0]    max_forwards_q;
	logic [LEN_W-1:0]    buffer_limit_q;

	// Captured request
	logic             cmd_q;
	logic [7:0]       ttl_q;
	logic             hbh_q;
	logic [7:0]       otype_q;
	logic [7:0]       olen_q;
	logic [SEQ_W-1:0] id_in_q;
	logic             idle_q;
	logic [15:0]      rnd_q;
	logic             member_q;
	logic             src_unspec_q;
	logic [LEN_W-1:0] plen_q;

	// Sequence-ID cache and counters
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [SEQ_W-1:0]       id_q [TABLE_DEPTH];
	logic [CNT_W-1:0]       cnt_q [TABLE_DEPTH];
	logic [PTR_W-1:0]       ptr_q;
	logic [SEQ_W-1:0]       seq_cnt_q;

	// Result under construction
	logic [1:0]       verdict_q;
	logic             fwd_q;
	logic [SEQ_W-1:0] oseq_q;
	logic [LEN_W-1:0] olen_out_q;
	logic [LEN_W-1:0] opay_q;
	logic [DLY_W-1:0] base_q;
	logic [DLY_W-1:0] delay_q;

	// Modulo unit
	logic [SPREAD_W-1:0] rem_q;
	logic [15:0]         rnd_sh_q;
	logic [STEP_W-1:0]   step_q;

	// Combinational evaluation
	logic                   hdr_ok;
	logic [TABLE_DEPTH-1:0] hit_vec;
	logic                   hit;
	logic [PTR_W-1:0]       hit_idx;
	logic                   can_fwd;
	logic [LEN_W:0]         grown_len;
	logic                   out_ok;
	logic                   fwd_c;
	logic [DLY_W-1:0]       base_c;
	logic [SPREAD_W:0]      trial;
	logic [SPREAD_W:0]      factor;
	logic [DLY_W+SPREAD_W:0] product;
	logic [SEQ_W-1:0]       seq_next;
	logic [PTR_W-1:0]       ptr_next;

	// Check the header, search the cache and form the lengths, base delay and product
	always_comb begin
		hdr_ok = (ttl_q > 8'd1) && hbh_q && (otype_q == OPT_TYPE_MCAST)
			&& (olen_q == OPT_LEN_MCAST);
		hit_idx = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_vec[i] = valid_q[i] && (id_q[i] == id_in_q);
		end
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (hit_vec[i]) hit_idx = PTR_W'(i);
		end
		hit = |hit_vec;
		can_fwd = (cnt_q[hit_idx] < max_forwards_q) && idle_q;
		grown_len = {1'b0, plen_q} + {1'b0, ADDED_BYTES};
		out_ok = !src_unspec_q && (grown_len <= {1'b0, buffer_limit_q});
		fwd_c = (cmd_q == CMD_INBOUND) && hdr_ok && (!hit || can_fwd);
		if ((min_delay_q != '0) && (check_interval_q < min_delay_q)) begin
			base_c = min_delay_q;
		end else begin
			base_c = check_interval_q;
		end
		seq_next = seq_cnt_q + SEQ_W'(1);
		if (ptr_q == PTR_W'(TABLE_DEPTH - 1)) begin
			ptr_next = '0;
		end else begin
			ptr_next = ptr_q + PTR_W'(1);
		end
		trial = {rem_q, rnd_sh_q[15]};
		factor = (max_spread_q == '0) ? (SPREAD_W+1)'(1) : {1'b0, rem_q} + (SPREAD_W+1)'(1);
		product = (DLY_W+SPREAD_W+1)'(base_q) * (DLY_W+SPREAD_W+1)'(factor);
	end

	assign status.fwd = fwd_c;
	assign status.spread_zero = (max_spread_q == '0);
	assign status.mod_last = (step_q == STEP_W'(MOD_STEPS - 1));

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_interval_q <= 16'd16;
			min_delay_q <= '0;
			max_spread_q <= '0;
			max_forwards_q <= CNT_W'(1);
			buffer_limit_q <= 16'd1280;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_CHECK_INTERVAL: check_interval_q <= cfg_wdata;
				CFG_MIN_DELAY:      min_delay_q <= cfg_wdata;
				CFG_MAX_SPREAD:     max_spread_q <= cfg_wdata[SPREAD_W-1:0];
				CFG_MAX_FORWARDS:   max_forwards_q <= cfg_wdata[CNT_W-1:0];
				CFG_BUFFER_LIMIT:   buffer_limit_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Update cache control state and the sequence counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ptr_q <= '0;
			seq_cnt_q <= '0;
			for (int i = 0; i < TABLE_DEPTH; i++) cnt_q[i] <= '0;
		end else if (cmd.eval) begin
			if (cmd_q == CMD_OUTBOUND) begin
				if (out_ok) seq_cnt_q <= seq_next;
			end else if (hdr_ok) begin
				if (hit) begin
					if (can_fwd) cnt_q[hit_idx] <= cnt_q[hit_idx] + CNT_W'(1);
				end else begin
					valid_q[ptr_q] <= 1'b1;
					cnt_q[ptr_q] <= CNT_W'(1);
					ptr_q <= ptr_next;
				end
			end
		end
	end

	// Capture the request, build the result, run modulo and scaling
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			ttl_q <= ttl;
			hbh_q <= proto_is_hbh;
			otype_q <= option_type;
			olen_q <= option_len;
			id_in_q <= {seq_high[6:0], seq_low};
			idle_q <= timer_idle;
			rnd_q <= random_value;
			member_q <= is_member;
			src_unspec_q <= source_unspecified;
			plen_q <= packet_len;
		end
		if (cmd.eval) begin
			fwd_q <= fwd_c;
			base_q <= base_c;
			delay_q <= '0;
			rem_q <= '0;
			rnd_sh_q <= rnd_q;
			step_q <= '0;
			if (cmd_q == CMD_OUTBOUND && out_ok) begin
				verdict_q <= VERDICT_SENT;
				oseq_q <= seq_next;
				olen_out_q <= grown_len[LEN_W-1:0];
				opay_q <= grown_len[LEN_W-1:0] - IPV6_HDR_BYTES;
			end else begin
				verdict_q <= (cmd_q == CMD_INBOUND && hdr_ok && !hit && member_q)
					? VERDICT_ACCEPT : VERDICT_DROP;
				oseq_q <= '0;
				olen_out_q <= '0;
				opay_q <= '0;
			end
			if (cmd_q == CMD_INBOUND && hdr_ok && !hit) begin
				id_q[ptr_q] <= id_in_q;
			end
		end
		// Restoring step: shift in one dividend bit, subtract if it fits
		if (cmd.mod_step) begin
			if (trial >= {1'b0, max_spread_q}) begin
				rem_q <= SPREAD_W'(trial - {1'b0, max_spread_q});
			end else begin
				rem_q <= trial[SPREAD_W-1:0];
			end
			rnd_sh_q <= {rnd_sh_q[14:0], 1'b0};
			step_q <= step_q + STEP_W'(1);
		end
		if (cmd.mul) begin
			delay_q <= product[DLY_W-1:0];
		end
		if (cmd.out_load) begin
			verdict <= verdict_q;
			forward_now <= fwd_q;
			forward_delay <= fwd_q ? delay_q : '0;
			out_seq <= oseq_q;
			out_len <= olen_out_q;
			out_payload_len <= opay_q;
		end
	end

endmodule
`default_nettype wire

FILE: sv/multicast_duplicate_forward_filter.sv
// Top level of the multicast duplicate forward filter.
// Instantiates mdf_ctrl and mdf_dpath; depends on mdf_pkg.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    command .. packet_len
//   out      out_valid/out_ready  verdict .. out_payload_len
//   cfg      cfg_wen              cfg_index, cfg_wdata
//
// A forwarded inbound request with a nonzero spread passes evaluation, sixteen
// modulo steps, the multiply and the output load. A forward with zero spread
// skips the modulo steps; anything else goes from evaluation to the output load.
// The next request is taken once the controller is back in idle. Reset clears
// the cache valid bits, counts, replace pointer and sequence counter at once. A
// full output register holds the controller before the output load; a new
// request is taken while a finished result still waits.
`default_nettype none
module multicast_duplicate_forward_filter (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_wen,
	input  wire [mdf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [mdf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire                           command,
	input  wire [7:0]                     ttl,
	input  wire                           proto_is_hbh,
	input  wire [7:0]                     option_type,
	input  wire [7:0]                     option_len,
	input  wire [7:0]                     seq_high,
	input  wire [7:0]                     seq_low,
	input  wire                           timer_idle,
	input  wire [15:0]                    random_value,
	input  wire                           is_member,
	input  wire                           source_unspecified,
	input  wire [mdf_pkg::LEN_W-1:0]      packet_len,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [1:0]                    verdict,
	output logic                          forward_now,
	output logic [mdf_pkg::DLY_W-1:0]     forward_delay,
	output logic [mdf_pkg::SEQ_W-1:0]     out_seq,
	output logic [mdf_pkg::LEN_W-1:0]     out_len,
	output logic [mdf_pkg::LEN_W-1:0]     out_payload_len
);
	import mdf_pkg::*;

	mdf_cmd_t    cmd;
	mdf_status_t status;

	// Sequence the request
	mdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Evaluate and hold the result
	mdf_dpath u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.cfg_wen            (cfg_wen),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.command            (command),
		.ttl                (ttl),
		.proto_is_hbh       (proto_is_hbh),
		.option_type        (option_type),
		.option_len         (option_len),
		.seq_high           (seq_high),
		.seq_low            (seq_low),
		.timer_idle         (timer_idle),
		.random_value       (random_value),
		.is_member          (is_member),
		.source_unspecified (source_unspecified),
		.packet_len         (packet_len),
		.verdict            (verdict),
		.forward_now        (forward_now),
		.forward_delay      (forward_delay),
		.out_seq            (out_seq),
		.out_len            (out_len),
		.out_payload_len    (out_payload_len)
	);

endmodule
`default_nettype wire

FILE: test/multicast_duplicate_forward_filter_tb.sv
// Testbench for multicast_duplicate_forward_filter: header checks, sequence-ID cache,
// forward delay scaling and outbound header insertion, checked against a built-in predictor.
// Depends on mdf_pkg and the RTL of the block; stands alone otherwise.
`timescale 1ns / 1ps
module multicast_duplicate_forward_filter_tb;
	import mdf_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 30;
	localparam int ITEMS_PER_PHASE = 210;
	localparam int RANDOM_PHASES = 8;
	localparam int POOL_SIZE = 6;

	// One request as presented on the input channel
	typedef struct packed {
		logic              command;
		logic [7:0]        ttl;
		logic              hbh;
		logic [7:0]        otype;
		logic [7:0]        olen;
		logic [7:0]        shigh;
		logic [7:0]        slow;
		logic              idle;
		logic [15:0]       rnd;
		logic              member;
		logic              src_unspec;
		logic [LEN_W-1:0]  plen;
	} hdr_request_t;

	// One result as seen on the output channel
	typedef struct packed {
		logic [1:0]        verdict;
		logic              fwd;
		logic [DLY_W-1:0]  delay;
		logic [SEQ_W-1:0]  seq;
		logic [LEN_W-1:0]  len;
		logic [LEN_W-1:0]  pay;
	} filter_result_t;

	// Tracks cache, counters and settings; predicts and checks verdicts
	class verdict_tracker;
		logic [15:0]       interval, min_dly, buf_limit;
		logic [7:0]        spread;
		logic [3:0]        fwd_limit;
		logic [15:0]       cache_id[TABLE_DEPTH];
		logic [3:0]        cache_cnt[TABLE_DEPTH];
		int unsigned       victim;
		logic [SEQ_W-1:0]  seq_ctr;
		filter_result_t    pending_verdicts[$];
		int mismatches, checked, hits, misses, sent, out_drops, hdr_drops;

		function new();
			interval = 16'd16;
			min_dly = 16'd0;
			spread = 8'd0;
			fwd_limit = 4'd1;
			buf_limit = 16'd1280;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				cache_id[i] = 16'hffff;
				cache_cnt[i] = 4'd0;
			end
			victim = 0;
			seq_ctr = '0;
			mismatches = 0;
			checked = 0;
			hits = 0;
			misses = 0;
			sent = 0;
			out_drops = 0;
			hdr_drops = 0;
		endfunction

		function void write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_CHECK_INTERVAL: interval = data;
				CFG_MIN_DELAY:      min_dly = data;
				CFG_MAX_SPREAD:     spread = data[7:0];
				CFG_MAX_FORWARDS:   fwd_limit = data[3:0];
				CFG_BUFFER_LIMIT:   buf_limit = data;
				default: ;
			endcase
		endfunction

		// Clamp the base delay, then scale it by the random spread factor
		function logic [15:0] scaled_delay(logic [15:0] rnd);
			logic [31:0] d;
			d = {16'd0, interval};
			if (min_dly != 16'd0 && d < {16'd0, min_dly})
				d = {16'd0, min_dly};
			if (spread != 8'd0)
				d = d * (32'd1 + ({16'd0, rnd} % {24'd0, spread}));
			return d[15:0];
		endfunction

		function void note_request(hdr_request_t r);
			filter_result_t want;
			logic [14:0] id;
			logic [16:0] grown;
			int slot;
			want = '0;
			want.verdict = VERDICT_DROP;
			if (r.command == CMD_OUTBOUND) begin
				grown = {1'b0, r.plen} + {1'b0, ADDED_BYTES};
				if (!r.src_unspec && grown <= {1'b0, buf_limit}) begin
					seq_ctr = seq_ctr + 1'b1;
					want.verdict = VERDICT_SENT;
					want.seq = seq_ctr;
					want.len = grown[15:0];
					want.pay = grown[15:0] - IPV6_HDR_BYTES;
					sent++;
				end else begin
					out_drops++;
				end
			end else if (r.ttl > 8'd1 && r.hbh && r.otype == OPT_TYPE_MCAST
					&& r.olen == OPT_LEN_MCAST) begin
				id = {r.shigh[6:0], r.slow};
				slot = -1;
				for (int i = 0; i < TABLE_DEPTH; i++)
					if (slot < 0 && cache_id[i] == {1'b0, id})
						slot = i;
				if (slot >= 0) begin
					// Hit: drop, maybe restart the forward timer
					hits++;
					if (cache_cnt[slot] < fwd_limit && r.idle) begin
						want.fwd = 1'b1;
						want.delay = scaled_delay(r.rnd);
						cache_cnt[slot] = cache_cnt[slot] + 1'b1;
					end
				end else begin
					// Miss: replace the round-robin victim, always forward
					misses++;
					cache_id[victim] = {1'b0, id};
					cache_cnt[victim] = 4'd1;
					victim = (victim + 1) % TABLE_DEPTH;
					want.fwd = 1'b1;
					want.delay = scaled_delay(r.rnd);
					want.verdict = r.member ? VERDICT_ACCEPT : VERDICT_DROP;
				end
			end else begin
				hdr_drops++;
			end
			pending_verdicts.push_back(want);
		endfunction

		function void check_result(filter_result_t got);
			filter_result_t want;
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing pending: verdict %0d fwd %0d delay %0d",
						$time, got.verdict, got.fwd, got.delay);
				return;
			end
			want = pending_verdicts.pop_front();
			checked++;
			if (got.verdict !== want.verdict || got.fwd !== want.fwd
					|| got.delay !== want.delay || got.seq !== want.seq
					|| got.len !== want.len || got.pay !== want.pay) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: mismatch: verdict %0d/%0d fwd %0d/%0d delay %0d/%0d ",
						"seq %0d/%0d len %0d/%0d payload %0d/%0d (expected/actual)"},
						$time, want.verdict, got.verdict, want.fwd, got.fwd,
						want.delay, got.delay, want.seq, got.seq,
						want.len, got.len, want.pay, got.pay);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	hdr_request_t req;
	logic out_valid;
	logic out_ready;
	logic [1:0] verdict;
	logic forward_now;
	logic [DLY_W-1:0] forward_delay;
	logic [SEQ_W-1:0] out_seq;
	logic [LEN_W-1:0] out_len;
	logic [LEN_W-1:0] out_payload_len;

	verdict_tracker tracker;
	logic [14:0] id_pool[POOL_SIZE];
	int quiet_cycles;
	int settings_applied;
	bit steady;
	int rx_stall, rx_run;

	multicast_duplicate_forward_filter dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wen            (cfg_wen),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.command            (req.command),
		.ttl                (req.ttl),
		.proto_is_hbh       (req.hbh),
		.option_type        (req.otype),
		.option_len         (req.olen),
		.seq_high           (req.shigh),
		.seq_low            (req.slow),
		.timer_idle         (req.idle),
		.random_value       (req.rnd),
		.is_member          (req.member),
		.source_unspecified (req.src_unspec),
		.packet_len         (req.plen),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.verdict            (verdict),
		.forward_now        (forward_now),
		.forward_delay      (forward_delay),
		.out_seq            (out_seq),
		.out_len            (out_len),
		.out_payload_len    (out_payload_len)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Note accepted requests, check accepted results, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wen)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (in_valid && in_ready)
				tracker.note_request(req);
			if (out_valid && out_ready)
				tracker.check_result({verdict, forward_now, forward_delay,
					out_seq, out_len, out_payload_len});
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d results outstanding",
					$time, quiet_cycles, tracker.pending_verdicts.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Stall the result side: alternate ready runs and stalls, unless held steady
	always @(negedge clk) begin
		if (steady) begin
			out_ready = 1'b1;
		end else if (rx_stall > 0) begin
			out_ready = 1'b0;
			rx_stall--;
		end else if (rx_run > 0) begin
			out_ready = 1'b1;
			rx_run--;
		end else begin
			rx_run = $urandom_range(0, 9);
			rx_stall = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 2);
			out_ready = 1'b1;
		end
	end

	function automatic hdr_request_t noise_request();
		hdr_request_t r;
		r.command = 1'($urandom_range(0, 1));
		r.ttl = 8'($urandom_range(0, 255));
		r.hbh = 1'($urandom_range(0, 1));
		r.otype = 8'($urandom_range(0, 255));
		r.olen = 8'($urandom_range(0, 255));
		r.shigh = 8'($urandom_range(0, 255));
		r.slow = 8'($urandom_range(0, 255));
		r.idle = 1'($urandom_range(0, 1));
		r.rnd = 16'($urandom_range(0, 65535));
		r.member = 1'($urandom_range(0, 1));
		r.src_unspec = 1'($urandom_range(0, 1));
		r.plen = 16'($urandom_range(0, 65535));
		return r;
	endfunction

	function automatic hdr_request_t well_formed(logic [14:0] id);
		hdr_request_t r;
		r = noise_request();
		r.command = CMD_INBOUND;
		r.ttl = 8'($urandom_range(2, 255));
		r.hbh = 1'b1;
		r.otype = OPT_TYPE_MCAST;
		r.olen = OPT_LEN_MCAST;
		r.shigh = {1'($urandom_range(0, 1)), id[14:8]};
		r.slow = id[7:0];
		return r;
	endfunction

	function automatic hdr_request_t outbound_req(logic src, logic [LEN_W-1:0] plen);
		hdr_request_t r;
		r = noise_request();
		r.command = CMD_OUTBOUND;
		r.src_unspec = src;
		r.plen = plen;
		return r;
	endfunction

	// Mostly valid headers from a small ID pool, some outbound, some broken headers
	function automatic hdr_request_t random_request();
		hdr_request_t r;
		int pick;
		logic [15:0] room;
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			room = tracker.buf_limit - ADDED_BYTES;
			r = outbound_req($urandom_range(0, 9) == 0, 16'($urandom_range(0, 65535)));
			case ($urandom_range(0, 3))
				0, 1: r.plen = 16'($urandom_range(0, room));
				2: r.plen = room - 16'd1 + 16'($urandom_range(0, 2));
				default: ;
			endcase
		end else if (pick < 85) begin
			if ($urandom_range(0, 99) < 85)
				r = well_formed(id_pool[$urandom_range(0, POOL_SIZE - 1)]);
			else
				r = well_formed(15'($urandom_range(0, 32767)));
		end else begin
			r = well_formed(id_pool[$urandom_range(0, POOL_SIZE - 1)]);
			case ($urandom_range(0, 4))
				0: r.ttl = 8'($urandom_range(0, 1));
				1: r.hbh = 1'b0;
				2: r.otype = 8'($urandom_range(0, 255));
				3: r.olen = 8'($urandom_range(0, 255));
				default: r = noise_request();
			endcase
		end
		return r;
	endfunction

	// Present one request and hold it until accepted
	task automatic send_request(input hdr_request_t r);
		@(negedge clk);
		req = r;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
	endtask

	task automatic hold_off(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
	endtask

	// Stop sending and wait until every predicted result has arrived
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (tracker.pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_wen = 1'b0;
		tracker.write_setting(idx, data);
	endtask

	task automatic apply_settings(input logic [15:0] interval, input logic [15:0] min_dly,
			input logic [7:0] spread, input logic [3:0] fwd_limit, input logic [15:0] limit);
		write_register(CFG_CHECK_INTERVAL, interval);
		write_register(CFG_MIN_DELAY, min_dly);
		write_register(CFG_MAX_SPREAD, {8'd0, spread});
		write_register(CFG_MAX_FORWARDS, {12'd0, fwd_limit});
		write_register(CFG_BUFFER_LIMIT, limit);
		settings_applied++;
	endtask

	// Send a phase of random requests in bursts with random gaps
	task automatic run_random(input int count);
		int burst;
		burst = 0;
		for (int n = 0; n < count; n++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 20);
				if (!steady)
					hold_off($urandom_range(0, 8));
			end
			burst--;
			if (!steady && $urandom_range(0, 149) == 0)
				drain_results();
			send_request(random_request());
		end
	endtask

	initial begin
		hdr_request_t r;
		logic [15:0] interval, min_dly, limit;
		logic [7:0] spread;
		logic [3:0] fwd_limit;
		int leftover;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		req = '0;
		out_ready = 1'b0;
		quiet_cycles = 0;
		settings_applied = 0;
		steady = 1'b0;
		rx_stall = 0;
		rx_run = 0;
		tracker = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: each header check, top bit of the ID ignored, hit at the limit
		r = well_formed(15'h0000);
		r.idle = 1'b0;
		r.member = 1'b1;
		r.ttl = 8'd0;
		send_request(r);
		r.ttl = 8'd1;
		send_request(r);
		r.ttl = 8'd2;
		send_request(r);
		r = well_formed(15'h0100);
		r.hbh = 1'b0;
		send_request(r);
		r = well_formed(15'h0100);
		r.otype = 8'h0D;
		send_request(r);
		r.otype = OPT_TYPE_MCAST;
		r.olen = 8'd3;
		send_request(r);
		r = well_formed(15'h7fff);
		r.shigh = 8'hff;
		r.ttl = 8'hff;
		r.member = 1'b0;
		send_request(r);
		r.shigh = 8'h7f;
		r.idle = 1'b1;
		send_request(r);
		// Outbound: short packet wraps the payload length, unspecified source, size limit
		send_request(outbound_req(1'b0, 16'd0));
		send_request(outbound_req(1'b1, 16'd100));
		send_request(outbound_req(1'b0, 16'd1272));
		send_request(outbound_req(1'b0, 16'd1273));
		send_request(outbound_req(1'b0, 16'hffff));
		drain_results();

		// Clamp active, widest spread, largest buffer
		apply_settings(16'd100, 16'd200, 8'd255, 4'd15, 16'hffff);
		r = well_formed(15'h1234);
		r.rnd = 16'hffff;
		r.idle = 1'b0;
		send_request(r);
		send_request(r);
		r.idle = 1'b1;
		r.rnd = 16'd254;
		send_request(r);
		r.rnd = 16'hfffe;
		send_request(r);
		send_request(outbound_req(1'b0, 16'd65527));
		send_request(outbound_req(1'b0, 16'd65528));
		r = well_formed(15'h0055);
		r.olen = 8'd0;
		send_request(r);
		drain_results();

		// Forward limit of zero, delay overflow, smallest buffer, cache eviction
		apply_settings(16'hffff, 16'd1, 8'd2, 4'd0, 16'd48);
		r = well_formed(15'h2000);
		r.rnd = 16'd1;
		send_request(r);
		r.idle = 1'b1;
		send_request(r);
		send_request(outbound_req(1'b0, 16'd40));
		send_request(outbound_req(1'b0, 16'd41));
		send_request(well_formed(15'h0003));
		send_request(well_formed(15'h0000));

		// Random phases, extremes first
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_results();
			case (phase)
				0: begin
					interval = 16'($urandom_range(0, 65535));
					min_dly = 16'd0;
					spread = 8'd0;
					fwd_limit = 4'd1;
					limit = 16'd1280;
				end
				1: begin
					interval = 16'd0;
					min_dly = 16'hffff;
					spread = 8'd255;
					fwd_limit = 4'd15;
					limit = 16'hffff;
				end
				2: begin
					interval = 16'hffff;
					min_dly = 16'd0;
					spread = 8'd1;
					fwd_limit = 4'd3;
					limit = 16'd48;
				end
				default: begin
					interval = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
						: 16'($urandom_range(0, 64));
					min_dly = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(0, 128));
					spread = 8'($urandom_range(0, 255));
					fwd_limit = 4'($urandom_range(1, 15));
					limit = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(48, 65535))
						: 16'($urandom_range(48, 2000));
				end
			endcase
			apply_settings(interval, min_dly, spread, fwd_limit, limit);
			for (int k = 0; k < POOL_SIZE; k++)
				id_pool[k] = 15'($urandom_range(0, 32767));
			steady = (phase == 4);
			run_random(ITEMS_PER_PHASE);
		end
		steady = 1'b0;
		drain_results();

		leftover = tracker.pending_verdicts.size();
		$display("Covered %0d results: %0d cache hits, %0d misses, %0d header drops,",
			tracker.checked, tracker.hits, tracker.misses, tracker.hdr_drops);
		$display("%0d outbound sent, %0d outbound drops, %0d register settings, %0d mismatches.",
			tracker.sent, tracker.out_drops, settings_applied, tracker.mismatches);
		if (tracker.mismatches == 0 && leftover == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: multicast_duplicate_forward_filter.f
sv/mdf_pkg.sv
sv/mdf_ctrl.sv
sv/mdf_dpath.sv
sv/multicast_duplicate_forward_filter.sv
test/multicast_duplicate_forward_filter_tb.sv
